/* sv/dbdf_pkg.sv */
// Package for the wire message deframer: phase and result codes, the result
// bundle passed from the parser to the emitter, and the message type tables.
// No dependencies.
`timescale 1ns / 1ps

package dbdf_pkg;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_TAG  = 2'd2,
      PH_BODY = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HDR  = 2'd0,
      KIND_BODY = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [2:0] SK_TYPED   = 3'd0;
   localparam logic [2:0] SK_SSL     = 3'd1;
   localparam logic [2:0] SK_GSSENC  = 3'd2;
   localparam logic [2:0] SK_CANCEL  = 3'd3;
   localparam logic [2:0] SK_STARTUP = 3'd4;
   localparam logic [2:0] SK_SSL_RSP = 3'd5;

   localparam logic [31:0] TAG_SSL    = 32'h04D2_162F;
   localparam logic [31:0] TAG_GSSENC = 32'h04D2_1630;
   localparam logic [31:0] TAG_CANCEL = 32'h04D2_162E;

   localparam logic [31:0] LEN_SHORT_REQ = 32'd8;
   localparam logic [31:0] LEN_CANCEL    = 32'd16;
   localparam logic [31:0] LEN_FIELD     = 32'd4;

   localparam logic [2:0] TAIL_NONE = 3'd0;
   localparam logic [2:0] TAIL_ONE  = 3'd1;
   localparam logic [2:0] TAIL_TAG  = 3'd4;

   // All results caused by one input byte: a head result followed by up to
   // four body results whose bytes are taken from tail_bytes, high byte first.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  type_byte;
      logic [2:0]  special_kind;
      logic [31:0] body_length;
      logic [7:0]  body_byte;
      logic        end_of_message;
      logic [2:0]  tail_count;
      logic [31:0] tail_bytes;
      logic        tail_eom;
   } bundle_type;

   // Message types a client may send.
   function automatic logic client_type_known(input logic [7:0] t);
      logic known;
      known = 1'b0;
      case (t) inside
         8'h70, 8'h51, 8'h50, 8'h42, 8'h45, 8'h44, 8'h43,
         8'h48, 8'h53, 8'h46, 8'h64, 8'h63, 8'h66, 8'h58: known = 1'b1;
         default: known = 1'b0;
      endcase
      return known;
   endfunction

   // Message types a server may send.
   function automatic logic server_type_known(input logic [7:0] t);
      logic known;
      known = 1'b0;
      case (t) inside
         8'h52, 8'h4B, 8'h53, 8'h31, 8'h32, 8'h33, 8'h43, 8'h74,
         8'h54, 8'h44, 8'h49, 8'h6E, 8'h45, 8'h4E, 8'h73, 8'h5A,
         8'h41, 8'h56, 8'h47, 8'h48, 8'h64, 8'h63, 8'h76: known = 1'b1;
         default: known = 1'b0;
      endcase
      return known;
   endfunction

endpackage

/* sv/dbdf_parser.sv */
// Framing state and single-pass decode of one payload byte into a result bundle.
// Depends on dbdf_pkg.
`timescale 1ns / 1ps

module dbdf_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                direction,
   input  logic                first_of_payload,
   input  logic                last_of_payload,
   output logic                bundle_valid,
   output dbdf_pkg::bundle_type bundle
);

   dbdf_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  fcnt_ff, fcnt_in;
   logic [31:0] len_ff, len_in;
   logic [23:0] tag_ff, tag_in;
   logic [7:0]  ctype_ff, ctype_in;
   logic [31:0] left_ff, left_in;
   logic        discard_ff, discard_in;

   always_comb begin
      dbdf_pkg::phase_type ph;
      logic [2:0]  fc;
      logic [31:0] len;
      logic [23:0] tag;
      logic [7:0]  ctype;
      logic [31:0] left;
      logic        disc;
      logic [2:0]  fc_next;
      logic [31:0] len_next;
      logic [31:0] tag_next;
      logic [31:0] left_next;
      logic        known;

      // A payload start wipes the framing state before the byte is judged.
      if (first_of_payload) begin
         ph    = dbdf_pkg::PH_TYPE;
         fc    = '0;
         len   = '0;
         tag   = '0;
         ctype = '0;
         left  = '0;
         disc  = 1'b0;
      end else begin
         ph    = phase_ff;
         fc    = fcnt_ff;
         len   = len_ff;
         tag   = tag_ff;
         ctype = ctype_ff;
         left  = left_ff;
         disc  = discard_ff;
      end

      fc_next   = fc + 3'd1;
      len_next  = {len[23:0], data_byte};
      tag_next  = {tag, data_byte};
      left_next = left - 32'd1;
      known     = direction ? dbdf_pkg::server_type_known(data_byte)
                            : dbdf_pkg::client_type_known(data_byte);

      phase_in   = ph;
      fcnt_in    = fc;
      len_in     = len;
      tag_in     = tag;
      ctype_in   = ctype;
      left_in    = left;
      discard_in = disc;

      bundle_valid = 1'b0;
      bundle       = '0;

      if (!disc) begin
         unique case (ph)
            dbdf_pkg::PH_TYPE: begin
               if (direction && first_of_payload && last_of_payload) begin
                  // Single-byte server payload: the SSL answer byte.
                  bundle_valid        = 1'b1;
                  bundle.kind         = dbdf_pkg::KIND_HDR;
                  bundle.special_kind = dbdf_pkg::SK_SSL_RSP;
                  bundle.body_length  = 32'd1;
                  bundle.tail_count   = dbdf_pkg::TAIL_ONE;
                  bundle.tail_bytes   = {data_byte, 24'd0};
                  bundle.tail_eom     = 1'b1;
               end else if (!direction && data_byte == 8'd0) begin
                  // Untyped message: this zero is the top length byte.
                  ctype_in = '0;
                  len_in   = '0;
                  fcnt_in  = 3'd1;
                  phase_in = dbdf_pkg::PH_LEN;
               end else if (!known) begin
                  bundle_valid     = 1'b1;
                  bundle.kind      = dbdf_pkg::KIND_ERR;
                  bundle.type_byte = data_byte;
                  discard_in       = 1'b1;
               end else begin
                  ctype_in = data_byte;
                  len_in   = '0;
                  fcnt_in  = '0;
                  phase_in = dbdf_pkg::PH_LEN;
               end
            end
            dbdf_pkg::PH_LEN: begin
               len_in  = len_next;
               fcnt_in = fc_next;
               if (fc_next[2]) begin
                  fcnt_in = '0;
                  if (ctype == 8'd0) begin
                     if (len_next < dbdf_pkg::LEN_SHORT_REQ) begin
                        bundle_valid = 1'b1;
                        bundle.kind  = dbdf_pkg::KIND_ERR;
                        discard_in   = 1'b1;
                     end else begin
                        tag_in   = '0;
                        phase_in = dbdf_pkg::PH_TAG;
                     end
                  end else if (len_next < dbdf_pkg::LEN_FIELD) begin
                     bundle_valid     = 1'b1;
                     bundle.kind      = dbdf_pkg::KIND_ERR;
                     bundle.type_byte = ctype;
                     discard_in       = 1'b1;
                  end else begin
                     left_in               = len_next - dbdf_pkg::LEN_FIELD;
                     bundle_valid          = 1'b1;
                     bundle.kind           = dbdf_pkg::KIND_HDR;
                     bundle.type_byte      = ctype;
                     bundle.body_length    = left_in;
                     bundle.end_of_message = (left_in == 32'd0);
                     phase_in = (left_in == 32'd0) ? dbdf_pkg::PH_TYPE : dbdf_pkg::PH_BODY;
                  end
               end
            end
            dbdf_pkg::PH_TAG: begin
               tag_in  = tag_next[23:0];
               fcnt_in = fc_next;
               if (fc_next[2]) begin
                  fcnt_in             = '0;
                  left_in             = len - dbdf_pkg::LEN_SHORT_REQ;
                  bundle_valid        = 1'b1;
                  bundle.kind         = dbdf_pkg::KIND_HDR;
                  bundle.special_kind = dbdf_pkg::SK_STARTUP;
                  if (len == dbdf_pkg::LEN_SHORT_REQ) begin
                     if (tag_next == dbdf_pkg::TAG_SSL) begin
                        bundle.special_kind = dbdf_pkg::SK_SSL;
                     end else if (tag_next == dbdf_pkg::TAG_GSSENC) begin
                        bundle.special_kind = dbdf_pkg::SK_GSSENC;
                     end
                  end else if (len == dbdf_pkg::LEN_CANCEL && tag_next == dbdf_pkg::TAG_CANCEL) begin
                     bundle.special_kind = dbdf_pkg::SK_CANCEL;
                  end
                  bundle.body_length = len - dbdf_pkg::LEN_FIELD;
                  bundle.tail_count  = dbdf_pkg::TAIL_TAG;
                  bundle.tail_bytes  = tag_next;
                  bundle.tail_eom    = (left_in == 32'd0);
                  phase_in = (left_in == 32'd0) ? dbdf_pkg::PH_TYPE : dbdf_pkg::PH_BODY;
               end
            end
            dbdf_pkg::PH_BODY: begin
               left_in               = left_next;
               bundle_valid          = 1'b1;
               bundle.kind           = dbdf_pkg::KIND_BODY;
               bundle.type_byte      = ctype;
               bundle.body_byte      = data_byte;
               bundle.end_of_message = (left_next == 32'd0);
               if (left_next == 32'd0) begin
                  phase_in = dbdf_pkg::PH_TYPE;
               end
            end
            default: begin
               phase_in = dbdf_pkg::PH_TYPE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= dbdf_pkg::PH_TYPE;
         fcnt_ff    <= '0;
         len_ff     <= '0;
         tag_ff     <= '0;
         ctype_ff   <= '0;
         left_ff    <= '0;
         discard_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         fcnt_ff    <= fcnt_in;
         len_ff     <= len_in;
         tag_ff     <= tag_in;
         ctype_ff   <= ctype_in;
         left_ff    <= left_in;
         discard_ff <= discard_in;
      end
   end

endmodule

/* sv/dbdf_emitter.sv */
// Two-slot bundle buffer and sequencer that plays each bundle out one result
// per transaction. Depends on dbdf_pkg.
`timescale 1ns / 1ps

module dbdf_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dbdf_pkg::bundle_type load_bundle,
   output logic                 can_load,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [1:0]           result_kind,
   output logic [7:0]           type_byte,
   output logic [2:0]           special_kind,
   output logic [31:0]          body_length,
   output logic [7:0]           body_byte,
   output logic                 end_of_message,
   output logic                 last
);

   logic                 act_valid_ff;
   dbdf_pkg::bundle_type act_ff;
   logic [2:0]           idx_ff;
   logic                 pend_valid_ff;
   dbdf_pkg::bundle_type pend_ff;

   logic at_end;
   logic act_free;
   logic take;

   assign at_end   = (idx_ff == act_ff.tail_count);
   assign take     = act_valid_ff && out_ready;
   assign act_free = !act_valid_ff || (take && at_end);
   assign can_load = !pend_valid_ff;

   assign out_valid = act_valid_ff;
   assign last      = at_end;

   always_comb begin
      if (idx_ff == 3'd0) begin
         result_kind    = act_ff.kind;
         type_byte      = act_ff.type_byte;
         special_kind   = act_ff.special_kind;
         body_length    = act_ff.body_length;
         body_byte      = act_ff.body_byte;
         end_of_message = act_ff.end_of_message;
      end else begin
         result_kind    = dbdf_pkg::KIND_BODY;
         type_byte      = '0;
         special_kind   = dbdf_pkg::SK_TYPED;
         body_length    = '0;
         body_byte      = act_ff.tail_bytes[31:24];
         end_of_message = at_end && act_ff.tail_eom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else if (act_free) begin
         idx_ff <= '0;
         if (pend_valid_ff) begin
            act_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else begin
            act_valid_ff <= load;
         end
      end else begin
         if (take) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (load) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (act_free) begin
         if (pend_valid_ff) begin
            act_ff <= pend_ff;
         end else if (load) begin
            act_ff <= load_bundle;
         end
      end else begin
         if (take && idx_ff != 3'd0) begin
            act_ff.tail_bytes <= {act_ff.tail_bytes[23:0], 8'd0};
         end
         if (load) begin
            pend_ff <= load_bundle;
         end
      end
   end

endmodule

/* sv/db_wire_message_deframer.sv */
// Top level of the wire message deframer: stream ports, parser and emitter.
// Depends on dbdf_pkg, dbdf_parser and dbdf_emitter.
`timescale 1ns / 1ps

// The block takes the payload bytes of one TCP direction on the req_ stream,
// one byte per transaction, and cuts them into protocol messages. For every
// message it sends a header transaction on the rsp_ stream (type, special
// kind, body length), then one transaction per body byte. Unknown types and
// short lengths give an error transaction and the rest of the payload is
// dropped; a byte marked as payload start always restarts framing.
// Each accepted byte is decoded in the cycle it is accepted; its results are
// registered in the emitter and appear on rsp_ once the output slot is free.
// Bytes with zero or one result go through at one byte per cycle while rsp_
// is ready. A byte that completes an untyped message tag yields five results
// and the single byte of an SSL response yields two; these occupy the output
// one transaction per result, which sets the rate while they drain.
// Results wait in a two-slot buffer, one slot per input byte. While the output
// is stalled the block keeps taking bytes until a second byte with results is
// held; req_tready then stays low until the last result of the older byte has
// been taken, and rises right after that transaction.
// rsp_tlast marks the final result that one input byte caused.
// Reset clears the framing state and empties the result buffer.
module db_wire_message_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] direction, [1] first_of_payload
   input  logic        req_tlast,   // last_of_payload
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] type_byte, [10:8] special_kind,
                                    // [42:11] body_length, [50:43] body_byte,
                                    // [55:51] zero
   output logic [2:0]  rsp_tuser,   // [1:0] result_kind, [2] end_of_message
   output logic        rsp_tlast    // last result of this input byte
);

   logic                 accept;
   logic                 bundle_valid;
   dbdf_pkg::bundle_type bundle;
   logic                 can_load;

   logic [1:0]  result_kind;
   logic [7:0]  type_byte;
   logic [2:0]  special_kind;
   logic [31:0] body_length;
   logic [7:0]  body_byte;
   logic        end_of_message;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   dbdf_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_tdata),
      .direction        (req_tuser[0]),
      .first_of_payload (req_tuser[1]),
      .last_of_payload  (req_tlast),
      .bundle_valid     (bundle_valid),
      .bundle           (bundle)
   );

   // Bytes that cause no result only move the framing state.
   dbdf_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .load           (accept && bundle_valid),
      .load_bundle    (bundle),
      .can_load       (can_load),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .result_kind    (result_kind),
      .type_byte      (type_byte),
      .special_kind   (special_kind),
      .body_length    (body_length),
      .body_byte      (body_byte),
      .end_of_message (end_of_message),
      .last           (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, body_byte, body_length, special_kind, type_byte};
   assign rsp_tuser = {end_of_message, result_kind};

endmodule

/* tb/db_wire_message_deframer_tb.sv */
// Self-checking testbench for db_wire_message_deframer: a frame tracker class
// predicts every result transaction and matches them as they leave the block.
// Depends on dbdf_pkg and the db_wire_message_deframer RTL.
`timescale 1ns / 1ps

// One expected result transaction, field by field.
typedef struct {
   dbdf_pkg::kind_type kind;
   logic [7:0]         type_byte;
   logic [2:0]         special_kind;
   logic [31:0]        body_length;
   logic [7:0]         body_byte;
   logic               end_of_message;
   logic               last;
} frame_result_type;

class frame_tracker_type;
   string               client_set = "pQPBEDCHSFdcfX";
   string               server_set = "RKS123CtTDInENsZAVGHdcv";
   int                  errors;
   frame_result_type    due_results[$];
   dbdf_pkg::phase_type phase;
   int unsigned         field_count;
   logic [31:0]         length_acc;
   logic [31:0]         tag_acc;
   logic [31:0]         body_left;
   logic [7:0]          cur_type;
   bit                  dropping;

   function new();
      errors = 0;
      restart();
   endfunction

   function void restart();
      phase       = dbdf_pkg::PH_TYPE;
      field_count = 0;
      length_acc  = '0;
      tag_acc     = '0;
      cur_type    = '0;
      body_left   = '0;
      dropping    = 1'b0;
   endfunction

   function bit known_type(logic [7:0] t, logic dir);
      string s;
      s = dir ? server_set : client_set;
      for (int i = 0; i < s.len(); i++)
         if (s[i] == t) return 1'b1;
      return 1'b0;
   endfunction

   function frame_result_type result(dbdf_pkg::kind_type kind, logic [7:0] t,
                                     logic [2:0] sk, logic [31:0] blen,
                                     logic [7:0] bb, logic eom);
      frame_result_type r;
      r.kind           = kind;
      r.type_byte      = t;
      r.special_kind   = sk;
      r.body_length    = blen;
      r.body_byte      = bb;
      r.end_of_message = eom;
      r.last           = 1'b0;
      return r;
   endfunction

   // Advances the framing state by one accepted byte and queues its results.
   function void take_byte(logic [7:0] b, logic dir, logic first, logic lastp);
      frame_result_type made[$];
      logic [2:0]       sk;
      if (first) restart();
      if (dropping) return;
      case (phase)
         dbdf_pkg::PH_TYPE: begin
            if (dir && first && lastp) begin
               made.push_back(result(dbdf_pkg::KIND_HDR, 8'h00, dbdf_pkg::SK_SSL_RSP,
                                     32'd1, 8'h00, 1'b0));
               made.push_back(result(dbdf_pkg::KIND_BODY, 8'h00, dbdf_pkg::SK_TYPED,
                                     32'd0, b, 1'b1));
            end else if (!dir && b == 8'h00) begin
               cur_type    = 8'h00;
               length_acc  = '0;
               field_count = 1;
               phase       = dbdf_pkg::PH_LEN;
            end else if (!known_type(b, dir)) begin
               made.push_back(result(dbdf_pkg::KIND_ERR, b, dbdf_pkg::SK_TYPED, 32'd0,
                                     8'h00, 1'b0));
               dropping = 1'b1;
            end else begin
               cur_type    = b;
               length_acc  = '0;
               field_count = 0;
               phase       = dbdf_pkg::PH_LEN;
            end
         end
         dbdf_pkg::PH_LEN: begin
            length_acc = {length_acc[23:0], b};
            field_count++;
            if (field_count >= 4) begin
               field_count = 0;
               if (cur_type == 8'h00) begin
                  if (length_acc < dbdf_pkg::LEN_SHORT_REQ) begin
                     made.push_back(result(dbdf_pkg::KIND_ERR, 8'h00, dbdf_pkg::SK_TYPED,
                                           32'd0, 8'h00, 1'b0));
                     dropping = 1'b1;
                  end else begin
                     tag_acc = '0;
                     phase   = dbdf_pkg::PH_TAG;
                  end
               end else if (length_acc < dbdf_pkg::LEN_FIELD) begin
                  made.push_back(result(dbdf_pkg::KIND_ERR, cur_type, dbdf_pkg::SK_TYPED,
                                        32'd0, 8'h00, 1'b0));
                  dropping = 1'b1;
               end else begin
                  body_left = length_acc - dbdf_pkg::LEN_FIELD;
                  made.push_back(result(dbdf_pkg::KIND_HDR, cur_type, dbdf_pkg::SK_TYPED,
                                        body_left, 8'h00, body_left == 0));
                  phase = (body_left != 0) ? dbdf_pkg::PH_BODY : dbdf_pkg::PH_TYPE;
               end
            end
         end
         dbdf_pkg::PH_TAG: begin
            tag_acc = {tag_acc[23:0], b};
            field_count++;
            if (field_count >= 4) begin
               field_count = 0;
               sk = dbdf_pkg::SK_STARTUP;
               if (length_acc == dbdf_pkg::LEN_SHORT_REQ) begin
                  if (tag_acc == dbdf_pkg::TAG_SSL) sk = dbdf_pkg::SK_SSL;
                  else if (tag_acc == dbdf_pkg::TAG_GSSENC) sk = dbdf_pkg::SK_GSSENC;
               end else if (length_acc == dbdf_pkg::LEN_CANCEL &&
                            tag_acc == dbdf_pkg::TAG_CANCEL) begin
                  sk = dbdf_pkg::SK_CANCEL;
               end
               body_left = length_acc - dbdf_pkg::LEN_SHORT_REQ;
               made.push_back(result(dbdf_pkg::KIND_HDR, 8'h00, sk,
                                     length_acc - dbdf_pkg::LEN_FIELD, 8'h00, 1'b0));
               // The buffered tag goes out as the first four body bytes.
               for (int k = 3; k >= 0; k--)
                  made.push_back(result(dbdf_pkg::KIND_BODY, 8'h00, dbdf_pkg::SK_TYPED,
                                        32'd0, tag_acc[8*k +: 8],
                                        k == 0 && body_left == 0));
               phase = (body_left != 0) ? dbdf_pkg::PH_BODY : dbdf_pkg::PH_TYPE;
            end
         end
         dbdf_pkg::PH_BODY: begin
            body_left--;
            made.push_back(result(dbdf_pkg::KIND_BODY, cur_type, dbdf_pkg::SK_TYPED, 32'd0,
                                  b, body_left == 0));
            if (body_left == 0) phase = dbdf_pkg::PH_TYPE;
         end
         default: ;
      endcase
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) due_results.push_back(made[i]);
   endfunction

   function void same_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   function void match_result(logic [55:0] tdata, logic [2:0] tuser, logic tlast);
      frame_result_type w;
      if (due_results.size() == 0) begin
         errors++;
         $display("%0t: result expected none actual tdata %h tuser %h tlast %b",
                  $time, tdata, tuser, tlast);
         return;
      end
      w = due_results.pop_front();
      same_field("result_kind", 32'(w.kind), 32'(tuser[1:0]));
      same_field("type_byte", 32'(w.type_byte), 32'(tdata[7:0]));
      same_field("special_kind", 32'(w.special_kind), 32'(tdata[10:8]));
      same_field("body_length", w.body_length, tdata[42:11]);
      same_field("body_byte", 32'(w.body_byte), 32'(tdata[50:43]));
      same_field("tdata padding", 32'd0, 32'(tdata[55:51]));
      same_field("end_of_message", 32'(w.end_of_message), 32'(tuser[2]));
      same_field("last", 32'(w.last), 32'(tlast));
   endfunction

   function int due_count();
      return due_results.size();
   endfunction
endclass

// The testbench feeds whole TCP payloads into the req_ stream, one byte per
// transaction, with the first byte carrying first_of_payload in tuser and the
// final byte carrying tlast. Each accepted byte is handed to the frame tracker,
// which predicts the result transactions it causes. A monitor takes every
// result transaction accepted on rsp_ and matches it with the oldest
// prediction. Both sides insert random idle cycles per transaction, with some
// payloads sent with no idling at all, and once the receiver holds off for a
// long stretch so that the two-slot result buffer fills and req_tready drops.
module db_wire_message_deframer_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;   // [0] direction, [1] first_of_payload
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // [7:0] type, [10:8] special kind, [42:11] body
                                  // length, [50:43] body byte, [55:51] zero
   logic [2:0]  rsp_tuser;        // [1:0] result kind, [2] end_of_message
   logic        rsp_tlast;

   frame_tracker_type tracker = new();

   // Payload under construction: bit 8 is the direction, bits 7:0 the byte.
   logic [8:0]  payload[$];
   int          bytes_fed = 0;
   bit          req_idle = 1'b1;
   bit          rsp_idle = 1'b1;
   bit          long_hold = 1'b0;
   bit          hold_done = 1'b0;

   db_wire_message_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or a prediction is never met.
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // All signals are driven with nonblocking assignments at the rising edge,
   // so sampling in the active region of an edge sees the values that the
   // block saw at that edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Result sink: waits a random number of cycles before each transaction, and
   // once, on request, holds tready low for a long stretch of its own count.
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      forever begin
         if (long_hold && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         gap = rsp_idle ? $urandom_range(0, 10) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offers one byte and returns at the edge where the transaction is taken.
   // A zero gap keeps tvalid high straight into the next byte.
   task automatic send_item(input logic [7:0] b, input logic dir, input logic first,
                            input logic lastp);
      int gap;
      gap = req_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {first, dir};
      req_tlast  <= lastp;
      do @(posedge clock); while (!req_tready);
      tracker.take_byte(b, dir, first, lastp);
      bytes_fed++;
   endtask

   task automatic send_payload();
      int last_i;
      last_i = payload.size() - 1;
      for (int i = 0; i <= last_i; i++)
         send_item(payload[i][7:0], payload[i][8], i == 0, i == last_i);
      payload.delete();
   endtask

   function void add_byte(logic dir, logic [7:0] b);
      payload.push_back({dir, b});
   endfunction

   function void add_random(logic dir, int n);
      repeat (n) add_byte(dir, 8'($urandom_range(0, 255)));
   endfunction

   // Typed message: type byte, big-endian length, then n body bytes. The body
   // count is given apart from the length so that messages can be cut short.
   function void add_typed(logic dir, logic [7:0] t, logic [31:0] len, int n);
      add_byte(dir, t);
      for (int k = 3; k >= 0; k--) add_byte(dir, len[8*k +: 8]);
      add_random(dir, n);
   endfunction

   // Untyped client message: the zero lead byte is the top byte of the length.
   function void add_untyped(logic [31:0] len, logic [31:0] tag, int n);
      add_byte(1'b0, 8'h00);
      for (int k = 2; k >= 0; k--) add_byte(1'b0, len[8*k +: 8]);
      for (int k = 3; k >= 0; k--) add_byte(1'b0, tag[8*k +: 8]);
      add_random(1'b0, n);
   endfunction

   function logic [7:0] pick_type(logic dir);
      string s;
      s = dir ? tracker.server_set : tracker.client_set;
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // One well-formed message with random content. Bodies are mostly short.
   function void add_good(logic dir);
      int          pick;
      int          n;
      logic [31:0] len;
      pick = $urandom_range(0, 9);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      len = $urandom_range(0, 1) ? dbdf_pkg::LEN_SHORT_REQ : dbdf_pkg::LEN_CANCEL;
      if (dir || pick < 6) begin
         add_typed(dir, pick_type(dir), 32'(n + 4), n);
      end else begin
         case (pick)
            6: add_untyped(dbdf_pkg::LEN_SHORT_REQ,
                           $urandom_range(0, 1) ? dbdf_pkg::TAG_SSL : dbdf_pkg::TAG_GSSENC,
                           0);
            7: add_untyped(dbdf_pkg::LEN_CANCEL, dbdf_pkg::TAG_CANCEL, 8);
            8: add_untyped(32'(dbdf_pkg::LEN_SHORT_REQ + n), 32'h0003_0000, n);
            // A request length with a tag that matches no request code.
            default: add_untyped(len, $urandom, int'(len - dbdf_pkg::LEN_SHORT_REQ));
         endcase
      end
   endfunction

   initial begin
      int   n;
      int   cut;
      int   i;
      logic dir;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed payloads. An empty typed body followed by a GSSENC request.
      add_typed(1'b0, "X", 4, 0);
      add_untyped(dbdf_pkg::LEN_SHORT_REQ, dbdf_pkg::TAG_GSSENC, 0);
      send_payload();
      // A server payload of one byte is an SSL response.
      add_byte(1'b1, 8'hFF);
      send_payload();
      // Unknown client type: error, the rest of the payload is dropped.
      add_byte(1'b0, 8'hFF);
      add_random(1'b0, 2);
      send_payload();
      // A zero type byte from the server is unknown too.
      add_byte(1'b1, 8'h00);
      add_byte(1'b1, 8'h00);
      send_payload();
      // Typed length below the length field itself.
      add_typed(1'b0, "p", 3, 0);
      add_byte(1'b0, 8'h00);
      send_payload();
      // Untyped length too short to hold the tag.
      add_untyped(32'd7, 32'hFFFF_FFFF, 0);
      send_payload();
      // Largest length: the body is cut off by the payload end and abandoned.
      add_typed(1'b1, "d", 32'hFFFF_FFFF, 1);
      send_payload();
      // Direction flips inside a payload: the body byte is marked as client
      // traffic, and the next type byte is judged by the client table.
      add_typed(1'b1, "Z", 5, 1);
      payload[5][8] = 1'b0;
      add_typed(1'b0, "Q", 4, 0);
      add_untyped(dbdf_pkg::LEN_SHORT_REQ, dbdf_pkg::TAG_SSL, 0);
      send_payload();
      add_untyped(dbdf_pkg::LEN_CANCEL, dbdf_pkg::TAG_CANCEL, 8);
      send_payload();

      // Random payloads: mostly runs of well-formed messages, the rest noise.
      bytes_fed = 0;
      while (bytes_fed < 380) begin
         req_idle = ($urandom_range(0, 9) < 7);
         rsp_idle = ($urandom_range(0, 9) < 7);
         dir = 1'($urandom_range(0, 1));
         if (!hold_done && bytes_fed >= 150) begin
            // Long receiver hold while the sender keeps offering bytes.
            hold_done = 1'b1;
            req_idle  = 1'b0;
            long_hold = 1'b1;
            repeat (4) add_typed(1'b0, pick_type(1'b0), 12, 8);
         end else if ($urandom_range(0, 99) < 75) begin
            n = $urandom_range(1, 3);
            repeat (n) add_good(dir);
            if ($urandom_range(0, 9) == 0) begin
               i = $urandom_range(1, payload.size() - 1);
               payload[i][8] = ~payload[i][8];
            end
         end else begin
            case ($urandom_range(0, 5))
               0: add_byte(1'b1, 8'($urandom_range(0, 255)));
               1: begin
                  add_byte(dir, 8'($urandom_range(0, 255)));
                  add_random(dir, $urandom_range(4, 10));
               end
               2: begin
                  add_good(dir);
                  cut = $urandom_range(1, payload.size() - 1);
                  repeat (cut) void'(payload.pop_back());
               end
               3: begin
                  if (dir || $urandom_range(0, 1))
                     add_typed(dir, pick_type(dir), $urandom_range(0, 3), 0);
                  else
                     add_untyped($urandom_range(0, 7), $urandom, 0);
                  add_random(dir, $urandom_range(0, 3));
               end
               4: repeat ($urandom_range(1, 8))
                     add_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               default: add_typed(dir, pick_type(dir), $urandom, $urandom_range(0, 5));
            endcase
         end
         send_payload();
      end
      req_tvalid <= 1'b0;

      // Drain: every prediction must be met, then watch for stray results.
      while (tracker.due_count() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
